// ===== hw/rtl/fbtt_pkg.sv =====
// ---------------------------------------------------------------------------
// fbtt_pkg
// Shared types and constants for the flow byte top-k tracker.
// ---------------------------------------------------------------------------
`default_nettype none
package fbtt_pkg;

  localparam int FLOW_SLOTS_DEF = 64;
  localparam int TOP_COUNT_DEF  = 5;
  localparam int BYTES_W        = 40;
  localparam int LEN_W          = 16;
  localparam int RANK_W         = 3;
  localparam int INTERVAL_W     = 8;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd20;
  localparam logic [BYTES_W-1:0]    BYTES_MAX    = {BYTES_W{1'b1}};

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_t;

  localparam logic [1:0] REG_INTERVAL = 2'd0;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_key_t;

  // broadcast control from sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic any_hit;
    logic take_en;
    logic clr_taken;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fbtt_in_if.sv =====
// ---------------------------------------------------------------------------
// fbtt_in_if
// Request channel: flow records and ticks.
// ---------------------------------------------------------------------------
`default_nettype none
interface fbtt_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [15:0] byte_len;

  modport source (output valid, req_type, src_ip, dst_ip, sport, dport, byte_len,
                  input ready);
  modport sink (input valid, req_type, src_ip, dst_ip, sport, dport, byte_len,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fbtt_out_if.sv =====
// ---------------------------------------------------------------------------
// fbtt_out_if
// Result channel: reported flows.
// ---------------------------------------------------------------------------
`default_nettype none
interface fbtt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_src_ip;
  logic [31:0] out_dst_ip;
  logic [15:0] out_sport;
  logic [15:0] out_dport;
  logic [39:0] byte_total;
  logic [2:0]  rank;
  logic        last;

  modport source (output valid, out_src_ip, out_dst_ip, out_sport, out_dport,
                  byte_total, rank, last, input ready);
  modport sink (input valid, out_src_ip, out_dst_ip, out_sport, out_dport,
                byte_total, rank, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fbtt_cell.sv =====
// ---------------------------------------------------------------------------
// fbtt_cell
// One flow slot: key match, byte accumulate, and one stage of the max chain.
// ---------------------------------------------------------------------------
`default_nettype none
module fbtt_cell
  import fbtt_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int FW  = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cell_ctl_t           ctl,
  input  wire flow_key_t           in_key,
  input  wire flow_key_t           req_key,
  input  wire logic [LEN_W-1:0]    req_len,
  input  wire logic [FW-1:0]       fill,
  input  wire logic [IW-1:0]       take_idx,
  output logic                     hit,
  input  wire logic                cand_vld_i,
  input  wire logic [BYTES_W-1:0]  cand_bytes_i,
  input  wire flow_key_t           cand_key_i,
  input  wire logic [IW-1:0]       cand_idx_i,
  output logic                     cand_vld_o,
  output logic [BYTES_W-1:0]       cand_bytes_o,
  output flow_key_t                cand_key_o,
  output logic [IW-1:0]            cand_idx_o
);

  flow_key_t          key_r;
  logic [BYTES_W-1:0] bytes_r;
  logic               hit_r;
  logic               taken_r;
  logic               vld;
  logic               alloc;
  logic               own;
  logic [BYTES_W:0]   sum;

  assign vld   = (FW'(IDX) < fill);
  assign alloc = ctl.upd_en && !ctl.any_hit && (fill == FW'(IDX));
  assign sum   = {1'b0, bytes_r} + {{(BYTES_W + 1 - LEN_W){1'b0}}, req_len};
  assign hit   = hit_r;
  assign own   = vld && !taken_r && (!cand_vld_i || bytes_r > cand_bytes_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      taken_r <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        hit_r <= vld && (key_r == in_key);
      end else if (ctl.upd_en) begin
        hit_r <= 1'b0;
      end
      if (ctl.clr_taken) begin
        taken_r <= 1'b0;
      end else if (ctl.take_en && take_idx == IW'(IDX)) begin
        taken_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_en && hit_r) begin
      bytes_r <= sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
    end else if (alloc) begin
      key_r   <= req_key;
      bytes_r <= {{(BYTES_W - LEN_W){1'b0}}, req_len};
    end
  end

  // strict compare keeps the lower slot on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_vld_o <= 1'b0;
    end else begin
      cand_vld_o <= own || cand_vld_i;
    end
    cand_bytes_o <= own ? bytes_r : cand_bytes_i;
    cand_key_o   <= own ? key_r : cand_key_i;
    cand_idx_o   <= own ? IW'(IDX) : cand_idx_i;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/flow_byte_topk_tracker.sv =====
// ---------------------------------------------------------------------------
// flow_byte_topk_tracker
// Flow table with byte totals and periodic top-flow reports.
// ---------------------------------------------------------------------------
// Requests arrive on in_chan (valid/ready). A record matches its key against
// all slots at once, then adds its length or fills the next free slot if one
// is left; the match is registered on accept and ST_REC does the update. A
// tick is handled on accept. When a tick pushes the tick count past
// report_interval, the block reports up to TOP_COUNT flows on out_chan,
// largest first, rank 0 upwards, last set on the final one. Each ranked flow
// is found by a maximum wave that walks the row of slot cells in ST_SWEEP and
// then waits in the output register until taken; a stalled receiver simply
// holds the block. No request is taken during a report.
// report_interval is written through the cfg_ APB port (byte address 0).
// Reset empties the table, clears the tick count and sets the interval to
// 20; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
module flow_byte_topk_tracker
  import fbtt_pkg::*;
#(
  parameter int FLOW_SLOTS = FLOW_SLOTS_DEF,
  parameter int TOP_COUNT  = TOP_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fbtt_in_if.sink          in_chan,
  fbtt_out_if.source       out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int IW = $clog2(FLOW_SLOTS);
  localparam int FW = $clog2(FLOW_SLOTS + 1);
  localparam int RW = $clog2(TOP_COUNT + 1);
  localparam int CW = $clog2(FLOW_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC,
    ST_SWEEP,
    ST_OUT
  } state_t;

  state_t                state_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic [INTERVAL_W-1:0] tick_r;
  logic [INTERVAL_W-1:0] tick_inc;
  logic [FW-1:0]         fill_r;
  logic [CW-1:0]         cnt_r;
  logic [RW-1:0]         round_r;
  flow_key_t             req_key_r;
  logic [LEN_W-1:0]      req_len_r;
  flow_key_t             in_key;
  cell_ctl_t             ctl;
  logic                  in_acc;
  logic                  out_acc;
  logic                  is_last;
  logic                  any_hit;
  logic [FLOW_SLOTS-1:0] hits;

  logic                  cv [FLOW_SLOTS+1];
  logic [BYTES_W-1:0]    cb [FLOW_SLOTS+1];
  flow_key_t             ck [FLOW_SLOTS+1];
  logic [IW-1:0]         ci [FLOW_SLOTS+1];

  flow_key_t             res_key_r;
  logic [BYTES_W-1:0]    res_bytes_r;
  logic                  res_last_r;

  assign in_key  = '{src_ip: in_chan.src_ip, dst_ip: in_chan.dst_ip,
                     sport: in_chan.sport, dport: in_chan.dport};
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;
  assign any_hit = |hits;
  assign tick_inc = (tick_r == {INTERVAL_W{1'b1}}) ? tick_r : tick_r + 1'b1;
  assign is_last = (int'(round_r) + 1 == TOP_COUNT) || (int'(round_r) + 1 == int'(fill_r));

  assign in_chan.ready = (state_r == ST_IDLE);
  assign out_chan.valid = (state_r == ST_OUT);
  assign out_chan.out_src_ip   = res_key_r.src_ip;
  assign out_chan.out_dst_ip   = res_key_r.dst_ip;
  assign out_chan.out_sport    = res_key_r.sport;
  assign out_chan.out_dport    = res_key_r.dport;
  assign out_chan.byte_total   = res_bytes_r;
  assign out_chan.rank         = RANK_W'(round_r);
  assign out_chan.last         = res_last_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32 - INTERVAL_W){1'b0}}, interval_r};

  always_comb begin
    ctl.cmp_en    = in_acc && (in_chan.req_type == REQ_RECORD);
    ctl.upd_en    = (state_r == ST_REC);
    ctl.any_hit   = any_hit;
    ctl.take_en   = (state_r == ST_SWEEP) && (int'(cnt_r) == FLOW_SLOTS);
    ctl.clr_taken = in_acc && (in_chan.req_type == REQ_TICK);
  end

  assign cv[0] = 1'b0;
  assign cb[0] = '0;
  assign ck[0] = '0;
  assign ci[0] = '0;

  for (genvar g = 0; g < FLOW_SLOTS; g++) begin : g_cell
    fbtt_cell #(.IDX(g), .IW(IW), .FW(FW)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .in_key       (in_key),
      .req_key      (req_key_r),
      .req_len      (req_len_r),
      .fill         (fill_r),
      .take_idx     (ci[FLOW_SLOTS]),
      .hit          (hits[g]),
      .cand_vld_i   (cv[g]),
      .cand_bytes_i (cb[g]),
      .cand_key_i   (ck[g]),
      .cand_idx_i   (ci[g]),
      .cand_vld_o   (cv[g+1]),
      .cand_bytes_o (cb[g+1]),
      .cand_key_o   (ck[g+1]),
      .cand_idx_o   (ci[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_key_r <= in_key;
      req_len_r <= in_chan.byte_len;
    end
    if (ctl.take_en) begin
      res_key_r   <= ck[FLOW_SLOTS];
      res_bytes_r <= cb[FLOW_SLOTS];
      res_last_r  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      interval_r <= INTERVAL_RST;
      tick_r     <= '0;
      fill_r     <= '0;
      cnt_r      <= '0;
      round_r    <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == REG_INTERVAL) begin
        interval_r <= cfg_pwdata[INTERVAL_W-1:0];
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_chan.req_type == REQ_RECORD) begin
              state_r <= ST_REC;
            end else if (tick_inc > interval_r) begin
              tick_r  <= '0;
              cnt_r   <= '0;
              round_r <= '0;
              if (fill_r != '0) begin
                state_r <= ST_SWEEP;
              end
            end else begin
              tick_r <= tick_inc;
            end
          end
        end
        ST_REC: begin
          if (!any_hit && int'(fill_r) < FLOW_SLOTS) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (ctl.take_en) begin
            state_r <= ST_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            cnt_r <= '0;
            if (res_last_r) begin
              state_r <= ST_IDLE;
            end else begin
              round_r <= round_r + 1'b1;
              state_r <= ST_SWEEP;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fbtt_checker.sv =====
// ---------------------------------------------------------------------------
// fbtt_checker
// Port-level checks on the tracker, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module fbtt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] rank,
  input wire logic       last,
  input wire logic       cfg_pready
);

  // no request taken while a report is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("request ready during report");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(last))
    else $error("result dropped while stalled");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !out_valid) else $error("result after last");

  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> !in_ready) else $error("report cut short");

  a_apb: assert property (@(posedge clk) cfg_pready) else $error("pready low");

endmodule

bind flow_byte_topk_tracker fbtt_checker u_fbtt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .rank       (out_chan.rank),
  .last       (out_chan.last),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

// ===== bench/flow_byte_topk_tracker_checker.sv =====
// ---------------------------------------------------------------------------
// Flow top-k report checker
// Watches the request, result and cfg ports of the flow byte top-k tracker,
// keeps its own copy of the flow table, tick count and interval, predicts
// every report run and compares each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module flow_byte_topk_tracker_checker
  import fbtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fbtt_in_if          in_mon,
  fbtt_out_if         out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fails,
  output int          pending
);

  localparam int SLOTS = FLOW_SLOTS_DEF;

  typedef struct packed {
    flow_key_t          key;
    logic [BYTES_W-1:0] total;
    logic [RANK_W-1:0]  rank;
    logic               last;
  } flow_report_t;

  logic                  tbl_valid [SLOTS];
  flow_key_t             tbl_key   [SLOTS];
  logic [BYTES_W-1:0]    tbl_bytes [SLOTS];
  logic                  tbl_taken [SLOTS];
  logic [INTERVAL_W-1:0] interval;
  logic [7:0]            ticks;
  flow_report_t          report_q[$];

  flow_report_t          got, want, entry;
  flow_key_t             rec_key;
  logic [BYTES_W:0]      sum;
  int                    free_slot, best, n;
  logic                  hit;

  assign pending = report_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
      interval = INTERVAL_RST;
      ticks    = '0;
      fails    = 0;
      report_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{key: '{out_mon.out_src_ip, out_mon.out_dst_ip, out_mon.out_sport,
                       out_mon.out_dport},
                total: out_mon.byte_total, rank: out_mon.rank, last: out_mon.last};
        if (report_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (req_type_t'(in_mon.req_type) == REQ_RECORD) begin
          rec_key = '{in_mon.src_ip, in_mon.dst_ip, in_mon.sport, in_mon.dport};
          free_slot = -1;
          hit = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit && tbl_valid[i] && tbl_key[i] == rec_key) begin
              sum = tbl_bytes[i] + in_mon.byte_len;
              tbl_bytes[i] = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
              hit = 1'b1;
            end else if (!tbl_valid[i] && free_slot < 0) begin
              free_slot = i;
            end
          end
          if (!hit && free_slot >= 0) begin
            tbl_valid[free_slot] = 1'b1;
            tbl_key[free_slot]   = rec_key;
            tbl_bytes[free_slot] = BYTES_W'(in_mon.byte_len);
          end
        end else begin
          if (ticks != 8'hFF) ticks++;
          if (ticks > interval) begin
            ticks = '0;
            n = 0;
            for (int i = 0; i < SLOTS; i++) tbl_taken[i] = 1'b0;
            for (int r = 0; r < TOP_COUNT_DEF; r++) begin
              best = -1;
              for (int i = 0; i < SLOTS; i++)
                if (tbl_valid[i] && !tbl_taken[i] &&
                    (best < 0 || tbl_bytes[i] > tbl_bytes[best]))
                  best = i;
              if (best >= 0) begin
                tbl_taken[best] = 1'b1;
                entry = '{key: tbl_key[best], total: tbl_bytes[best],
                          rank: RANK_W'(n), last: 1'b0};
                report_q = {report_q, entry};
                n++;
              end
            end
            if (n > 0) report_q[report_q.size()-1].last = 1'b1;
          end
        end
      end

      // the block sees a new interval only from the next request on
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == REG_INTERVAL)
        interval = cfg_pwdata[INTERVAL_W-1:0];
    end
  end

endmodule

// ===== bench/flow_byte_topk_tracker_tb.sv =====
// ---------------------------------------------------------------------------
// Flow byte top-k tracker testbench
// Drives records and ticks with random gaps, stalls the report side at random
// and steps the report interval through its extremes while the block is idle.
// The checker alongside predicts and compares every reported flow.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module flow_byte_topk_tracker_tb;
  import fbtt_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        idle_en;
  int          fails, pending;
  int          cycles = 0;
  flow_key_t   used_keys[$];

  fbtt_in_if  in_chan();
  fbtt_out_if out_chan();

  flow_byte_topk_tracker i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  flow_byte_topk_tracker_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    out_chan.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic flow_key_t fresh_key();
    return '{$urandom, $urandom, 16'($urandom), 16'($urandom)};
  endfunction

  task automatic send_request(req_type_t kind, flow_key_t key, logic [15:0] len);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= kind;
    in_chan.src_ip   <= key.src_ip;
    in_chan.dst_ip   <= key.dst_ip;
    in_chan.sport    <= key.sport;
    in_chan.dport    <= key.dport;
    in_chan.byte_len <= len;
    forever begin
      @(negedge clk);
      if (in_chan.ready) break;
    end
    @(posedge clk);
  endtask

  task automatic send_record(flow_key_t key, logic [15:0] len);
    used_keys = {used_keys, key};
    send_request(REQ_RECORD, key, len);
  endtask

  task automatic send_tick();
    send_request(REQ_TICK, fresh_key(), 16'($urandom));
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_interval(logic [7:0] value);
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_INTERVAL;
    cfg_pwdata  <= {16'($urandom), 8'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(int count);
    flow_key_t key;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_tick();
      end else begin
        if (used_keys.size() > 0 && $urandom_range(0, 9) < 6)
          key = used_keys[$urandom_range(0, used_keys.size() - 1)];
        else
          key = fresh_key();
        send_record(key, ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
      end
    end
  endtask

  initial begin
    idle_en        = 1'b1;
    rst_n          <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    in_chan.valid    <= 1'b0;
    in_chan.req_type <= REQ_RECORD;
    in_chan.src_ip   <= '0;
    in_chan.dst_ip   <= '0;
    in_chan.sport    <= '0;
    in_chan.dport    <= '0;
    in_chan.byte_len <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: due report emits nothing
    write_interval(8'd0);
    send_tick();
    send_record('0, 16'h0000);
    send_record('1, 16'hFFFF);
    send_record('1, 16'hFFFF);
    send_record('{32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443}, 16'd100);
    send_record('{32'h0A00_0003, 32'h0A00_0004, 16'd53, 16'd53}, 16'd100);
    send_tick();
    send_record('{32'h0B00_0001, 32'hC0A8_0001, 16'd22, 16'd2222}, 16'd5);
    send_record('{32'h0B00_0002, 32'hC0A8_0002, 16'd1, 16'd65535}, 16'd1);
    send_tick();
    send_tick();

    write_interval(8'd1);
    random_items(12);
    write_interval(8'd2);
    random_items(10);
    write_interval(8'($urandom_range(3, 9)));
    random_items(8);

    // fill past capacity so new flows are dropped
    write_interval(8'd1);
    repeat (60) send_record(fresh_key(), 16'($urandom));

    // top interval never reports
    write_interval(8'd255);
    repeat (3) send_tick();

    write_interval(8'd3);
    idle_en = 1'b0;
    random_items(10);
    drain();

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
